// File: sv/fbn_pkg.sv
// shared types and constants for the forgiving base64 normalizer
`timescale 1ns / 1ps

package fbn_pkg;

  // action codes of an input item
  localparam logic ACT_CHAR = 1'b0;
  localparam logic ACT_END  = 1'b1;

  // padding character
  localparam logic [7:0] PAD_CHAR = 8'h3D;

  // depth of the queue between front and back
  localparam int unsigned Q_DEPTH = 2;
  localparam int unsigned Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int unsigned Q_CNT_W = $clog2(Q_DEPTH + 1);

  // completion codes carried on the final item
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_PAD  = 2'd1,
    ST_BAD_LEN  = 2'd2,
    ST_BAD_CHAR = 2'd3
  } status_e;

  // input item
  typedef struct packed {
    logic       action;
    logic [7:0] char_code;
  } in_item_t;

  // result item
  typedef struct packed {
    logic [7:0] out_char;
    logic       last;
    status_e    status;
  } out_item_t;

  // work handed from front to back: one character or one end of text
  typedef struct packed {
    logic       is_end;
    logic [7:0] ch;
    logic [1:0] pads;
    status_e    status;
  } cmd_t;

endpackage

// File: sv/fbn_front.sv
// front end: classifies characters, tracks padding state, issues commands
`timescale 1ns / 1ps

module fbn_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  fbn_pkg::in_item_t in_item_i,
  output logic              push_o,
  output fbn_pkg::cmd_t     cmd_o,
  input  logic              full_i
);
  import fbn_pkg::*;

  logic [1:0] kept_q, kept_d;
  logic [1:0] run_q, run_d;
  logic       saw_pad_q, saw_pad_d;
  logic       bad_q, bad_d;

  logic       accept;
  logic       is_blank;
  logic       is_pad;
  logic       is_alpha;
  logic [7:0] c;
  status_e    end_st;
  logic [1:0] end_pads;

  assign c          = in_item_i.char_code;
  assign in_stall_o = full_i;
  assign accept     = in_valid_i && !full_i;

  // character classes
  assign is_blank = (c == 8'h09) || (c == 8'h0A) || (c == 8'h0C) ||
                    (c == 8'h0D) || (c == 8'h20);
  assign is_pad   = (c == PAD_CHAR);
  assign is_alpha = (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A) ||
                    (c >= 8'h30 && c <= 8'h39) || (c == 8'h2B) || (c == 8'h2F);

  // end of text checks: padding, then length, then characters
  always_comb begin
    end_st   = ST_OK;
    end_pads = 2'd0;
    if (kept_q == 2'd0) begin
      if (run_q > 2'd2) end_st = ST_BAD_PAD;
      else end_pads = run_q;
    end else begin
      if (saw_pad_q) end_st = ST_BAD_PAD;
      else if (kept_q == 2'd1) end_st = ST_BAD_LEN;
      else end_pads = 2'(3'd4 - {1'b0, kept_q});
    end
    if (end_st == ST_OK && bad_q) end_st = ST_BAD_CHAR;
    if (end_st != ST_OK) end_pads = 2'd0;
  end

  // state update
  always_comb begin
    kept_d    = kept_q;
    run_d     = run_q;
    saw_pad_d = saw_pad_q;
    bad_d     = bad_q;
    if (accept) begin
      if (in_item_i.action == ACT_END) begin
        kept_d    = 2'd0;
        run_d     = 2'd0;
        saw_pad_d = 1'b0;
        bad_d     = 1'b0;
      end else if (!is_blank) begin
        kept_d = kept_q + 2'd1;
        if (is_pad) begin
          saw_pad_d = 1'b1;
          if (run_q != 2'd3) run_d = run_q + 2'd1;
        end else begin
          if (run_q != 2'd0) begin
            bad_d = 1'b1;
            run_d = 2'd0;
          end
          if (!is_alpha) bad_d = 1'b1;
        end
      end
    end
  end

  // command to the back end
  always_comb begin
    push_o = accept && ((in_item_i.action == ACT_END) || is_alpha);
    cmd_o.is_end = (in_item_i.action == ACT_END);
    cmd_o.ch     = c;
    cmd_o.pads   = end_pads;
    cmd_o.status = end_st;
    if (in_item_i.action != ACT_END) begin
      cmd_o.pads   = 2'd0;
      cmd_o.status = ST_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kept_q    <= 2'd0;
      run_q     <= 2'd0;
      saw_pad_q <= 1'b0;
      bad_q     <= 1'b0;
    end else begin
      kept_q    <= kept_d;
      run_q     <= run_d;
      saw_pad_q <= saw_pad_d;
      bad_q     <= bad_d;
    end
  end

  // state starts over after an end of text
  a_clear_after_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && in_item_i.action == ACT_END |=>
      kept_q == 2'd0 && run_q == 2'd0 && !saw_pad_q && !bad_q)
    else $error("front state not cleared after end");

  // padding is only requested on a clean end
  a_pads_only_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o && cmd_o.pads != 2'd0 |-> cmd_o.is_end && cmd_o.status == ST_OK)
    else $error("pads requested on a failing end");

endmodule

// File: sv/fbn_queue.sv
// short command queue between front and back
`timescale 1ns / 1ps

module fbn_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  fbn_pkg::cmd_t cmd_i,
  output logic          full_o,
  output logic          valid_o,
  output fbn_pkg::cmd_t cmd_o,
  input  logic          pop_i
);
  import fbn_pkg::*;

  cmd_t                 mem_q [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [Q_CNT_W-1:0]   count_q;
  logic                 do_push, do_pop;

  assign full_o  = (count_q == Q_CNT_W'(Q_DEPTH));
  assign valid_o = (count_q != '0);
  assign cmd_o   = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= cmd_i;
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + Q_PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + Q_PTR_W'(1);
      end
      if (do_push && !do_pop) count_q <= count_q + Q_CNT_W'(1);
      else if (!do_push && do_pop) count_q <= count_q - Q_CNT_W'(1);
    end
  end

  // no command is dropped on a full queue
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("command pushed into full queue");

endmodule

// File: sv/fbn_back.sv
// back end: expands commands into result items through an output register
`timescale 1ns / 1ps

module fbn_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  fbn_pkg::cmd_t      cmd_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output fbn_pkg::out_item_t out_item_o
);
  import fbn_pkg::*;

  logic      out_valid_q, out_valid_d;
  out_item_t out_q, out_d;
  logic [1:0] pads_done_q, pads_done_d;
  logic      load;

  assign load = !out_valid_q || !out_stall_i;

  // choose the next item: character, pad or final status
  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    pads_done_d = pads_done_q;
    pop_o       = 1'b0;
    if (load) begin
      out_valid_d = valid_i;
      if (valid_i) begin
        if (!cmd_i.is_end) begin
          out_d.out_char = cmd_i.ch;
          out_d.last     = 1'b0;
          out_d.status   = ST_OK;
          pop_o          = 1'b1;
        end else if (pads_done_q != cmd_i.pads) begin
          out_d.out_char = PAD_CHAR;
          out_d.last     = 1'b0;
          out_d.status   = ST_OK;
          pads_done_d    = pads_done_q + 2'd1;
        end else begin
          out_d.out_char = 8'h00;
          out_d.last     = 1'b1;
          out_d.status   = cmd_i.status;
          pads_done_d    = 2'd0;
          pop_o          = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      pads_done_q <= 2'd0;
    end else begin
      out_valid_q <= out_valid_d;
      pads_done_q <= pads_done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // pad counter never runs past the two pads an end can need
  a_pad_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pads_done_q != 2'd3)
    else $error("pad counter out of range");

endmodule

// File: sv/forgiving_base64_normalizer_top.sv
// top level of the forgiving base64 normalizer
`timescale 1ns / 1ps

// Takes base64 text one character per item, then an end item. Whitespace is
// dropped, alphabet characters pass through the command queue and the output
// register, '=' is held back and rechecked at the end, where zero to two '='
// pads and a final status item (last set) follow. One input item is taken every
// cycle while the two-entry command queue has room; the output side sends one
// item per cycle while out_stall_i is low, so an end item, which yields one to
// three output items, holds the back end and the queue absorbs that.
module forgiving_base64_normalizer_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  fbn_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output fbn_pkg::out_item_t out_item_o
);
  import fbn_pkg::*;

  logic push, full, q_valid, pop;
  cmd_t push_cmd, head_cmd;

  // classification and padding state
  fbn_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .push_o     (push),
    .cmd_o      (push_cmd),
    .full_i     (full)
  );

  // decoupling queue
  fbn_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .full_o  (full),
    .valid_o (q_valid),
    .cmd_o   (head_cmd),
    .pop_i   (pop)
  );

  // result generation
  fbn_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (q_valid),
    .cmd_i       (head_cmd),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule
